FILE: rtl/asdg_pkg.sv
// Shared types and constants of the sine generator: command and register codes,
// field widths, reset values and the structs that pass between the modules.
// No dependencies.
`default_nettype none

package asdg_pkg;

    localparam int CMD_W     = 3;
    localparam int DELTA_W   = 8;
    localparam int FREQ_W    = 16;
    localparam int AMP_W     = 12;
    localparam int OFFS_W    = 12;
    localparam int STEP_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Input commands.
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREQ    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_AMP     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEUTRAL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UP      = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_UNIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_AMP    = 2'd2;

    // Reset values and limits.
    localparam logic [STEP_W-1:0] RST_STEP_UNIT = 32'd4295;
    localparam logic [OFFS_W-1:0] RST_CENTER    = 12'd2048;
    localparam logic [OFFS_W-1:0] RST_UP_AMP    = 12'd500;
    localparam logic [OFFS_W-1:0] RST_OFFSET    = 12'd2048;
    localparam logic [FREQ_W-1:0] RST_FREQ      = 16'd1;
    localparam logic [AMP_W-1:0]  RST_AMP       = 12'd1;
    localparam logic [FREQ_W-1:0] FREQ_MAX      = 16'hFFFF;
    localparam logic [AMP_W-1:0]  AMP_MAX       = 12'hFFF;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic [AMP_W-1:0]  amplitude;
        logic [OFFS_W-1:0] offset;
    } t_settings;

    typedef struct packed {
        logic      tick;
        logic      rejected;
        t_settings settings;
    } t_item_info;

    typedef struct packed {
        logic load_inc;  // capture the phase increment of the item entering stage two
        logic read;      // register a table read for the item leaving stage two
        logic advance;   // a valid item leaves stage two: add its increment
    } t_phase_ctl;

endpackage

`default_nettype wire

FILE: rtl/asdg_settings.sv
// Frequency, amplitude and offset settings and their update by one command.
// Depends on asdg_pkg.
`default_nettype none

module asdg_settings
    import asdg_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic [CMD_W-1:0]          i_command,
    input  wire logic signed [DELTA_W-1:0] i_delta,
    input  wire logic [OFFS_W-1:0]         i_center_offset,
    input  wire logic [OFFS_W-1:0]         i_up_amplitude,
    output t_settings                      o_next,
    output logic                           o_rejected
);

    t_settings r_set;
    t_settings n_set;
    logic signed [FREQ_W+1:0] freq_sum;
    logic signed [AMP_W+1:0]  amp_sum;

    assign freq_sum = $signed({2'b00, r_set.frequency}) + (FREQ_W+2)'(i_delta);
    assign amp_sum  = $signed({2'b00, r_set.amplitude}) + (AMP_W+2)'(i_delta);

    always_comb begin
        n_set      = r_set;
        o_rejected = 1'b0;
        unique case (i_command)
            CMD_FREQ: begin
                if (freq_sum < $signed((FREQ_W+2)'(1)) ||
                    freq_sum > $signed({2'b00, FREQ_MAX})) begin
                    o_rejected = 1'b1;
                end else begin
                    n_set.frequency = freq_sum[FREQ_W-1:0];
                end
            end
            CMD_AMP: begin
                if (amp_sum < $signed((AMP_W+2)'(1)) ||
                    amp_sum > $signed({2'b00, AMP_MAX})) begin
                    o_rejected = 1'b1;
                end else begin
                    n_set.amplitude = amp_sum[AMP_W-1:0];
                end
            end
            CMD_NEUTRAL: begin
                n_set.offset = i_center_offset;
            end
            CMD_UP: begin
                // The offset floors at zero when the up amplitude exceeds the center.
                n_set.offset = (i_up_amplitude > i_center_offset) ? '0
                             : i_center_offset - i_up_amplitude;
            end
            default: begin
            end
        endcase
    end

    assign o_next = n_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set.frequency <= RST_FREQ;
            r_set.amplitude <= RST_AMP;
            r_set.offset    <= RST_OFFSET;
        end else if (i_accept) begin
            r_set <= n_set;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/asdg_phase.sv
// Phase increment multiplier, phase accumulator and quarter-wave sine table.
// Depends on asdg_pkg.
`default_nettype none

module asdg_phase
    import asdg_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SINE_FRAC_BITS  = 15
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_phase_ctl              i_ctl,
    input  wire logic [FREQ_W-1:0]       i_frequency,
    input  wire logic [STEP_W-1:0]       i_step_unit,
    output logic [SINE_FRAC_BITS:0]      o_sine,
    output logic                         o_negate
);

    localparam int QUARTER_N = 1 << TABLE_ADDR_BITS;
    localparam int PROD_W    = FREQ_W + STEP_W;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [TABLE_ADDR_BITS:0] QUARTER_V = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

    typedef logic [SINE_FRAC_BITS:0] t_rom [0:QUARTER_N];

    // Taylor series of sin in Q30, each term truncated, then rounded half up.
    function automatic logic [SINE_FRAC_BITS:0] quarter_sine(input int k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        r;
        logic signed [63:0] sum;
        x    = (64'(k) * HALF_PI_Q30) >> TABLE_ADDR_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 13; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) sum = sum - $signed(term);
            else              sum = sum + $signed(term);
        end
        if (sum < 0) sum = '0;
        r = (64'(sum) + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS);
        if (r > (64'd1 << SINE_FRAC_BITS)) r = 64'd1 << SINE_FRAC_BITS;
        return r[SINE_FRAC_BITS:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k < QUARTER_N; k++) rom[k] = quarter_sine(k);
        rom[QUARTER_N] = (SINE_FRAC_BITS+1)'(1) << SINE_FRAC_BITS;
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [PROD_W-1:0]          n_prod;
    logic [PHASE_BITS-1:0]      r_inc;
    logic [PHASE_BITS-1:0]      r_phase;
    logic [PHASE_BITS-1:0]      n_phase;
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] idx;
    logic [TABLE_ADDR_BITS:0]   rom_idx;
    logic [SINE_FRAC_BITS:0]    r_sine;
    logic                       r_negate;

    assign n_prod = PROD_W'(i_frequency) * PROD_W'(i_step_unit);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_inc) begin
            r_inc <= n_prod[PHASE_BITS-1:0];
        end
    end

    // The table sees the phase before this item's own increment.
    assign quad    = r_phase[PHASE_BITS-1 -: 2];
    assign idx     = r_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign rom_idx = quad[0] ? QUARTER_V - {1'b0, idx} : {1'b0, idx};
    assign n_phase = r_phase + r_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_ctl.advance) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.read) begin
            r_sine   <= SINE_ROM[rom_idx];
            r_negate <= quad[1];
        end
    end

    assign o_sine   = r_sine;
    assign o_negate = r_negate;

endmodule

`default_nettype wire

FILE: rtl/asdg_sample.sv
// Sample scaling: amplitude times sine plus offset, floored and saturated to the
// DAC range, or zero for a non-tick, into the output code register. Depends on asdg_pkg.
`default_nettype none

module asdg_sample
    import asdg_pkg::*;
#(
    parameter int SINE_FRAC_BITS = 15,
    parameter int DAC_BITS       = 12
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_load,
    input  wire logic                    i_tick,
    input  wire logic [AMP_W-1:0]        i_amplitude,
    input  wire logic [OFFS_W-1:0]       i_offset,
    input  wire logic [SINE_FRAC_BITS:0] i_sine,
    input  wire logic                    i_negate,
    output logic [DAC_BITS-1:0]          o_dac_code
);

    localparam int PW = AMP_W + SINE_FRAC_BITS + 1;
    localparam int SW = PW + 2;
    localparam int MW = SW - 1 - SINE_FRAC_BITS;
    localparam int CW = (DAC_BITS > MW) ? DAC_BITS : MW;
    localparam logic [CW-1:0] CODE_MAX = CW'((64'd1 << DAC_BITS) - 64'd1);

    logic [PW-1:0]        prod;
    logic signed [SW-1:0] scaled;
    logic signed [SW-1:0] total;
    logic [CW-1:0]        mag;
    logic [DAC_BITS-1:0]  n_code;
    logic [DAC_BITS-1:0]  r_code;

    assign prod   = PW'(i_amplitude) * PW'(i_sine);
    assign scaled = i_negate ? -$signed(SW'(prod)) : $signed(SW'(prod));
    assign total  = scaled + $signed(SW'(i_offset) << SINE_FRAC_BITS);
    // Dropping the fraction bits of a two's complement value floors it.
    assign mag    = CW'(total[SW-2:SINE_FRAC_BITS]);

    always_comb begin
        if (!i_tick || total[SW-1]) begin
            n_code = '0;
        end else if (mag > CODE_MAX) begin
            n_code = CODE_MAX[DAC_BITS-1:0];
        end else begin
            n_code = mag[DAC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code <= n_code;
        end
    end

    assign o_dac_code = r_code;

endmodule

`default_nettype wire

FILE: rtl/adjustable_sine_dac_generator_core.sv
// Top level of the adjustable sine generator: handshakes, configuration registers
// and pipeline control. Depends on asdg_pkg, asdg_settings, asdg_phase, asdg_sample.
//
// Usage. Items enter on the input channel (i_in_valid / o_in_ready) with a command
// and a signed delta. Every item gives exactly one result on the output channel
// (o_out_valid / i_out_ready): a DAC code for a tick, a rejected flag for a refused
// adjust, and the frequency, amplitude and offset settings after the item.
// Configuration registers are written over a separate channel (i_cfg_valid /
// o_cfg_ready, i_cfg_index, i_cfg_data); it is always ready and must only be used
// while the block holds no item in flight. Unknown indexes are ignored.
//
// An item passes the stage one, two and three registers into the output register.
// Throughput is one item per cycle while the output is not stalled; the settings
// add-and-compare at acceptance and the phase accumulator add set it.
// A new item is taken while a finished result still waits, as long as any of the
// four pipeline registers is free; when the receiver stalls long enough all fill
// and o_in_ready drops, and nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline, clears the phase to zero,
// sets frequency and amplitude to one, the offset to 2048 and the registers to
// their defaults.
`default_nettype none

module adjustable_sine_dac_generator_core
    import asdg_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SINE_FRAC_BITS  = 15,
    parameter int DAC_BITS        = 12
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Input item channel.
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [CMD_W-1:0]          i_command,
    input  wire logic signed [DELTA_W-1:0] i_delta,
    // Result channel.
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [DAC_BITS-1:0]            o_dac_code,
    output logic                           o_sample_valid,
    output logic                           o_rejected,
    output logic [FREQ_W-1:0]              o_frequency_now,
    output logic [AMP_W-1:0]               o_amplitude_now,
    output logic [OFFS_W-1:0]              o_offset_now,
    // Configuration write channel.
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [STEP_W-1:0]         i_cfg_data
);

    // Configuration registers.
    logic [STEP_W-1:0] r_step_unit;
    logic [OFFS_W-1:0] r_center_offset;
    logic [OFFS_W-1:0] r_up_amplitude;
    logic              cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_unit     <= RST_STEP_UNIT;
            r_center_offset <= RST_CENTER;
            r_up_amplitude  <= RST_UP_AMP;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_STEP_UNIT: r_step_unit     <= i_cfg_data;
                CFG_CENTER:    r_center_offset <= i_cfg_data[OFFS_W-1:0];
                CFG_UP_AMP:    r_up_amplitude  <= i_cfg_data[OFFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline control. Each stage moves when it is empty or the one after moves,
    // so bubbles collapse and a stalled output does not block the input at once.
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_s3_valid;
    logic r_out_valid;
    logic en_s1;
    logic en_s2;
    logic en_s3;
    logic en_out;
    logic in_xfer;

    assign en_out     = !r_out_valid || i_out_ready;
    assign en_s3      = !r_s3_valid || en_out;
    assign en_s2      = !r_s2_valid || en_s3;
    assign en_s1      = !r_s1_valid || en_s2;
    assign o_in_ready = en_s1;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_s1)  r_s1_valid  <= i_in_valid;
            if (en_s2)  r_s2_valid  <= r_s1_valid;
            if (en_s3)  r_s3_valid  <= r_s2_valid;
            if (en_out) r_out_valid <= r_s3_valid;
        end
    end

    // Settings take effect at the transfer; the values after the item ride along.
    t_settings  set_next;
    logic       set_rejected;
    t_item_info n_s1_info;
    t_item_info r_s1_info;
    t_item_info r_s2_info;
    t_item_info r_s3_info;
    t_item_info r_out_info;

    asdg_settings u_settings (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_xfer),
        .i_command       (i_command),
        .i_delta         (i_delta),
        .i_center_offset (r_center_offset),
        .i_up_amplitude  (r_up_amplitude),
        .o_next          (set_next),
        .o_rejected      (set_rejected)
    );

    assign n_s1_info.tick     = (i_command == CMD_TICK);
    assign n_s1_info.rejected = set_rejected;
    assign n_s1_info.settings = set_next;

    always_ff @(posedge i_clk) begin
        if (en_s1)  r_s1_info  <= n_s1_info;
        if (en_s2)  r_s2_info  <= r_s1_info;
        if (en_s3)  r_s3_info  <= r_s2_info;
        if (en_out) r_out_info <= r_s3_info;
    end

    // Stage one computes the increment, stage two reads the table and advances
    // the phase, stage three scales the sample into the output register.
    t_phase_ctl              phase_ctl;
    logic [SINE_FRAC_BITS:0] sine;
    logic                    sine_negate;

    assign phase_ctl.load_inc = en_s2;
    assign phase_ctl.read     = en_s3;
    assign phase_ctl.advance  = en_s3 && r_s2_valid;

    asdg_phase #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SINE_FRAC_BITS  (SINE_FRAC_BITS)
    ) u_phase (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (phase_ctl),
        .i_frequency (r_s1_info.settings.frequency),
        .i_step_unit (r_step_unit),
        .o_sine      (sine),
        .o_negate    (sine_negate)
    );

    asdg_sample #(
        .SINE_FRAC_BITS (SINE_FRAC_BITS),
        .DAC_BITS       (DAC_BITS)
    ) u_sample (
        .i_clk       (i_clk),
        .i_load      (en_out),
        .i_tick      (r_s3_info.tick),
        .i_amplitude (r_s3_info.settings.amplitude),
        .i_offset    (r_s3_info.settings.offset),
        .i_sine      (sine),
        .i_negate    (sine_negate),
        .o_dac_code  (o_dac_code)
    );

    assign o_out_valid     = r_out_valid;
    assign o_sample_valid  = r_out_info.tick;
    assign o_rejected      = r_out_info.rejected;
    assign o_frequency_now = r_out_info.settings.frequency;
    assign o_amplitude_now = r_out_info.settings.amplitude;
    assign o_offset_now    = r_out_info.settings.offset;

endmodule

`default_nettype wire

FILE: rtl/asdg_checker.sv
// Port-level checks of the sine generator and the bind that attaches them.
// Depends on asdg_pkg and adjustable_sine_dac_generator_core.
`default_nettype none

module asdg_checker
    import asdg_pkg::*;
#(
    parameter int DAC_BITS = 12
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_in_ready,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [DAC_BITS-1:0]       o_dac_code,
    input wire logic                      o_sample_valid,
    input wire logic                      o_rejected,
    input wire logic [FREQ_W-1:0]         o_frequency_now,
    input wire logic [AMP_W-1:0]          o_amplitude_now,
    input wire logic [OFFS_W-1:0]         o_offset_now
);

    // A stalled result holds its code, frequency and offset.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_dac_code) &&
        $stable(o_frequency_now) && $stable(o_offset_now))
        else $error("result changed while stalled");

    // With the output register free the whole pipeline can move.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // A refused adjust is never a tick.
    a_reject_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> !o_sample_valid)
        else $error("rejected result carries a sample");

    // Non-tick results carry a zero code and frequency and amplitude stay nonzero.
    a_code_and_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_valid || o_dac_code == '0) &&
        o_frequency_now != '0 && o_amplitude_now != '0)
        else $error("bad code or setting in result");

endmodule

bind adjustable_sine_dac_generator_core asdg_checker #(.DAC_BITS(DAC_BITS)) u_asdg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_dac_code      (o_dac_code),
    .o_sample_valid  (o_sample_valid),
    .o_rejected      (o_rejected),
    .o_frequency_now (o_frequency_now),
    .o_amplitude_now (o_amplitude_now),
    .o_offset_now    (o_offset_now)
);

`default_nettype wire

FILE: tb/sv/adjustable_sine_dac_generator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the adjustable sine DAC generator core, with its own
// predictor of the phase accumulator, the quarter-wave table and the settings.
// Depends on asdg_pkg and adjustable_sine_dac_generator_core.

module adjustable_sine_dac_generator_core_tb;

    import asdg_pkg::*;

    // Widths of the block as instantiated (its default parameters).
    localparam int PHASE_W    = 32;
    localparam int LUT_ADDR_W = 10;
    localparam int SINE_FRAC  = 15;
    localparam int DAC_W      = 12;
    localparam int QUARTER_N  = 1 << LUT_ADDR_W;

    // Command codes that the block leaves unused; they only advance the phase.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    localparam int RESET_CYCLES   = 5;
    localparam int GAP_MAX        = 7;
    localparam int RX_HOLD_CYCLES = 100;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_MAX     = 10;
    localparam int CYCLE_LIMIT    = 300000;

    typedef longint unsigned u64_t;

    // Pi/2 in Q30, the argument scale of the table's series expansion.
    localparam u64_t HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [DELTA_W-1:0] delta;
    } dac_item_t;

    typedef struct packed {
        logic [DAC_W-1:0]  code;
        logic              sample_valid;
        logic              rejected;
        logic [FREQ_W-1:0] frequency;
        logic [AMP_W-1:0]  amplitude;
        logic [OFFS_W-1:0] offset;
    } dac_result_t;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic [CMD_W-1:0]          in_command = CMD_TICK;
    logic signed [DELTA_W-1:0] in_delta = '0;
    logic                      out_ready = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = CFG_STEP_UNIT;
    logic [STEP_W-1:0]         cfg_data = '0;

    wire                       in_ready;
    wire                       out_valid;
    wire [DAC_W-1:0]           dac_code;
    wire                       sample_valid;
    wire                       rejected;
    wire [FREQ_W-1:0]          frequency_now;
    wire [AMP_W-1:0]           amplitude_now;
    wire [OFFS_W-1:0]          offset_now;
    wire                       cfg_ready;

    // Predictor state: registers, settings and phase, kept at the block's widths.
    logic [STEP_W-1:0]  pred_step_unit;
    logic [OFFS_W-1:0]  pred_center;
    logic [OFFS_W-1:0]  pred_up_amp;
    logic [PHASE_W-1:0] pred_phase;
    logic [PHASE_W-1:0] pred_increment;
    logic [FREQ_W-1:0]  pred_freq;
    logic [AMP_W-1:0]   pred_amp;
    logic [OFFS_W-1:0]  pred_offset;
    int                 sine_lut [0:QUARTER_N];

    // Items waiting to be offered, and the results their transfers promise.
    dac_item_t   pending_items [$];
    dac_result_t expected_results [$];

    // Run control shared between the stimulus process and the clocked processes.
    logic no_idle = 1'b0;
    logic hold_request = 1'b0;
    logic hold_taken = 1'b0;
    logic rx_hold = 1'b0;
    int   hold_left = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;

    // Bookkeeping.
    int cycle_count = 0;
    int fail_count = 0;
    int report_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int samples_seen = 0;
    int rejects_seen = 0;
    int input_stalls = 0;
    int cfg_writes = 0;

    dac_item_t   next_item;
    dac_result_t observed;
    dac_result_t wanted;

    adjustable_sine_dac_generator_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_command       (in_command),
        .i_delta         (in_delta),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_dac_code      (dac_code),
        .o_sample_valid  (sample_valid),
        .o_rejected      (rejected),
        .o_frequency_now (frequency_now),
        .o_amplitude_now (amplitude_now),
        .o_offset_now    (offset_now),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------------

    // One quarter-wave entry: sin(k * pi/2 / QUARTER_N) from a truncated Taylor
    // series in Q30, rounded half up into Q(SINE_FRAC) and capped at 1.0.
    function automatic int quarter_sine(int k);
        u64_t   x;
        u64_t   x2;
        u64_t   term;
        u64_t   r;
        longint acc;
        x    = (u64_t'(k) * HALF_PI_Q30) / u64_t'(QUARTER_N);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 13; n++) begin
            term = ((term * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        r = (u64_t'(acc) + (u64_t'(1) << (29 - SINE_FRAC))) >> (30 - SINE_FRAC);
        if (r > (u64_t'(1) << SINE_FRAC)) begin
            r = u64_t'(1) << SINE_FRAC;
        end
        return int'(r);
    endfunction

    // The increment wraps at the phase width, so large step units alias.
    function automatic logic [PHASE_W-1:0] phase_increment_of();
        logic [PHASE_W-1:0] product;
        product = PHASE_W'(pred_freq) * PHASE_W'(pred_step_unit);
        return product;
    endfunction

    function automatic void predictor_reset();
        for (int k = 0; k < QUARTER_N; k++) begin
            sine_lut[k] = quarter_sine(k);
        end
        sine_lut[QUARTER_N] = 1 << SINE_FRAC;
        pred_step_unit = RST_STEP_UNIT;
        pred_center    = RST_CENTER;
        pred_up_amp    = RST_UP_AMP;
        pred_phase     = '0;
        pred_freq      = RST_FREQ;
        pred_amp       = RST_AMP;
        pred_offset    = RST_OFFSET;
        pred_increment = phase_increment_of();
    endfunction

    // Sample of the current phase: the top bits pick quadrant and table index,
    // odd quadrants mirror the table, the lower half negates it. The sum is
    // floored and then clipped into the DAC range.
    function automatic logic [DAC_W-1:0] dac_sample();
        logic [LUT_ADDR_W+1:0] addr;
        int                    sine_q;
        longint                acc;
        longint                code;
        addr = pred_phase[PHASE_W-1 -: LUT_ADDR_W + 2];
        if (addr[LUT_ADDR_W]) begin
            sine_q = sine_lut[QUARTER_N - int'(addr[LUT_ADDR_W-1:0])];
        end else begin
            sine_q = sine_lut[addr[LUT_ADDR_W-1:0]];
        end
        if (addr[LUT_ADDR_W+1]) begin
            sine_q = -sine_q;
        end
        acc  = longint'(pred_amp) * longint'(sine_q) + (longint'(pred_offset) << SINE_FRAC);
        code = acc >>> SINE_FRAC;
        if (code < 0) begin
            code = 0;
        end
        if (code > longint'((1 << DAC_W) - 1)) begin
            code = (1 << DAC_W) - 1;
        end
        return DAC_W'(code);
    endfunction

    // Applies one transferred item to the predictor and returns its result.
    // The command acts first, a tick samples the phase from before the item,
    // and the phase advances last.
    function automatic dac_result_t predict_dac_result(
        logic [CMD_W-1:0] cmd, logic signed [DELTA_W-1:0] delta);
        dac_result_t res;
        int          trial;
        res = '0;
        case (cmd)
            CMD_TICK: begin
                res.code         = dac_sample();
                res.sample_valid = 1'b1;
            end
            CMD_FREQ: begin
                trial = int'(pred_freq) + int'(delta);
                if (trial <= 0 || trial > int'(FREQ_MAX)) begin
                    res.rejected = 1'b1;
                end else begin
                    pred_freq      = FREQ_W'(trial);
                    pred_increment = phase_increment_of();
                end
            end
            CMD_AMP: begin
                trial = int'(pred_amp) + int'(delta);
                if (trial <= 0 || trial > int'(AMP_MAX)) begin
                    res.rejected = 1'b1;
                end else begin
                    pred_amp = AMP_W'(trial);
                end
            end
            CMD_NEUTRAL: begin
                pred_offset = pred_center;
            end
            CMD_UP: begin
                // The offset floors at zero when the up amount exceeds the center.
                pred_offset = (pred_up_amp > pred_center) ? '0 : pred_center - pred_up_amp;
            end
            default: begin
            end
        endcase
        pred_phase    = pred_phase + pred_increment;
        res.frequency = pred_freq;
        res.amplitude = pred_amp;
        res.offset    = pred_offset;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    function automatic void queue_item(logic [CMD_W-1:0] cmd, int delta);
        dac_item_t it;
        it.cmd   = cmd;
        it.delta = DELTA_W'(delta);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // Mostly ticks and adjusts with deltas in the nominal range; now and then a
    // delta anywhere in the 8-bit range or one of the unused commands.
    function automatic void queue_random_item();
        int pick;
        int delta;
        logic [CMD_W-1:0] cmd;
        pick = $urandom_range(99, 0);
        if (pick < 45) begin
            cmd = CMD_TICK;
        end else if (pick < 65) begin
            cmd = CMD_FREQ;
        end else if (pick < 85) begin
            cmd = CMD_AMP;
        end else if (pick < 91) begin
            cmd = CMD_NEUTRAL;
        end else if (pick < 96) begin
            cmd = CMD_UP;
        end else begin
            cmd = CMD_W'($urandom_range(CMD_SPARE_C, CMD_SPARE_A));
        end
        if ($urandom_range(9, 0) == 0) begin
            delta = int'($urandom_range(255, 0)) - 128;
        end else begin
            delta = int'($urandom_range(200, 0)) - 100;
        end
        queue_item(cmd, delta);
    endfunction

    // Returns at a falling edge once every queued item has been transferred
    // and every expected result has come back.
    task automatic wait_idle();
        do begin
            @(negedge clk);
        end while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // One register transfer on the configuration channel; the predictor takes
    // the new value at the edge of the transfer.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [STEP_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_STEP_UNIT: begin
                pred_step_unit = data;
                pred_increment = phase_increment_of();
            end
            CFG_CENTER: pred_center = data[OFFS_W-1:0];
            CFG_UP_AMP: pred_up_amp = data[OFFS_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic write_all_registers(input logic [STEP_W-1:0] step_unit,
                                       input logic [OFFS_W-1:0] center,
                                       input logic [OFFS_W-1:0] up_amp);
        write_register(CFG_STEP_UNIT, step_unit);
        write_register(CFG_CENTER, STEP_W'(center));
        write_register(CFG_UP_AMP, STEP_W'(up_amp));
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Input driver. After every transfer the sender draws how many cycles it
    // stays quiet before it offers the next pending item. The expected result
    // is predicted at the edge of the transfer itself.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (in_valid && !in_ready) begin
                input_stalls++;
            end
            if (in_valid && in_ready) begin
                expected_results.insert(expected_results.size(),
                                        predict_dac_result(in_command, in_delta));
                items_sent++;
                tx_gap = no_idle ? 0 : $urandom_range(GAP_MAX, 0);
            end
            // Valid stays up with the same payload until its transfer.
            if (!in_valid || in_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    in_valid   <= 1'b1;
                    in_command <= next_item.cmd;
                    in_delta   <= next_item.delta;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver hold-off. On request the receiver refuses results for a long
    // stretch so that the pipeline fills and the block stalls its input.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left = 0;
            rx_hold <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
            end else if (hold_request && !hold_taken) begin
                hold_left  = RX_HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            rx_hold <= (hold_left > 0);
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each transferred result is checked against the oldest
    // expectation, then the receiver draws its own pause before the next one.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                observed.code         = dac_code;
                observed.sample_valid = sample_valid;
                observed.rejected     = rejected;
                observed.frequency    = frequency_now;
                observed.amplitude    = amplitude_now;
                observed.offset       = offset_now;
                if (sample_valid) begin
                    samples_seen++;
                end
                if (rejected) begin
                    rejects_seen++;
                end
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (report_count < REPORT_MAX) begin
                        report_count++;
                        $display("unexpected result at cycle %0d: code %0d valid %0b rej %0b",
                                 cycle_count, dac_code, sample_valid, rejected);
                    end
                end else begin
                    wanted = expected_results.pop_front();
                    if (observed.code !== wanted.code
                        || observed.sample_valid !== wanted.sample_valid
                        || observed.rejected !== wanted.rejected
                        || observed.frequency !== wanted.frequency
                        || observed.amplitude !== wanted.amplitude
                        || observed.offset !== wanted.offset) begin
                        fail_count++;
                        if (report_count < REPORT_MAX) begin
                            report_count++;
                            $display("mismatch on result %0d:", results_seen);
                            $display("    expected code %0d valid %0b rej %0b freq %0d amp %0d offs %0d",
                                     wanted.code, wanted.sample_valid, wanted.rejected,
                                     wanted.frequency, wanted.amplitude, wanted.offset);
                            $display("    actual code %0d valid %0b rej %0b freq %0d amp %0d offs %0d",
                                     observed.code, observed.sample_valid, observed.rejected,
                                     observed.frequency, observed.amplitude, observed.offset);
                        end
                    end
                end
                rx_gap = no_idle ? 0 : $urandom_range(GAP_MAX, 0);
            end
            if (rx_hold) begin
                out_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a run that stops making progress ends here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. Phases run one after another; the registers change only while
    // nothing is in flight.
    // ------------------------------------------------------------------------
    initial begin
        predictor_reset();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings. The first tick samples phase zero, so it gives the bare
        // offset. Adjusts that would reach zero are refused, including the most
        // negative delta; the unused commands only move the phase.
        @(negedge clk);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_FREQ, -1);
        queue_item(CMD_FREQ, -128);
        queue_item(CMD_AMP, -1);
        queue_item(CMD_AMP, 127);
        queue_item(CMD_AMP, 127);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_FREQ, 127);
        queue_item(CMD_FREQ, 100);
        queue_item(CMD_TICK, -100);
        queue_item(CMD_TICK, 127);
        queue_item(CMD_UP, 0);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_NEUTRAL, -128);
        queue_item(CMD_SPARE_A, 55);
        queue_item(CMD_SPARE_B, -128);
        queue_item(CMD_SPARE_C, 127);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_FREQ, -100);
        queue_item(CMD_AMP, -100);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_FREQ, -127);
        queue_item(CMD_TICK, 0);
        wait_idle();

        // Largest step unit, zero center and an up amount above it: the up
        // command floors the offset at zero. The amplitude then ramps toward its
        // top, the adjusts that would pass it are refused, and negative half waves clip at 0.
        write_all_registers('1, '0, '1);
        queue_item(CMD_UP, 0);
        queue_item(CMD_TICK, 0);
        for (int n = 0; n < 32; n++) begin
            queue_item(CMD_AMP, 127);
        end
        queue_item(CMD_AMP, 30);
        queue_item(CMD_AMP, 1);
        queue_item(CMD_AMP, 127);
        for (int n = 0; n < 16; n++) begin
            queue_item(CMD_TICK, 0);
            queue_item(CMD_FREQ, int'($urandom_range(100, 1)));
        end
        // Random traffic while the receiver holds off for a long stretch.
        for (int n = 0; n < 100; n++) begin
            queue_random_item();
        end
        hold_request <= 1'b1;
        wait_idle();

        // Zero step unit freezes the phase; top center with no up amount gives
        // the largest offset, and with a large amplitude the code clips high.
        write_all_registers('0, '1, '0);
        queue_item(CMD_NEUTRAL, 0);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_UP, 0);
        queue_item(CMD_AMP, 127);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_FREQ, 1);
        queue_item(CMD_TICK, 0);
        wait_idle();

        // Random registers. Frequency ramps up back to back, with ticks mixed
        // in along the way.
        write_all_registers(STEP_W'($urandom), OFFS_W'($urandom), OFFS_W'($urandom));
        no_idle = 1'b1;
        for (int n = 0; n < 60; n++) begin
            queue_item(CMD_FREQ, 127);
            if (n % 4 == 3) begin
                queue_item(CMD_TICK, 0);
            end
        end
        queue_item(CMD_FREQ, 1);
        wait_idle();
        no_idle = 1'b0;
        for (int n = 0; n < 80; n++) begin
            queue_random_item();
        end
        wait_idle();

        // Small random step unit so that the phase walks slowly through the
        // quadrants, with new center and up amount.
        write_all_registers(STEP_W'($urandom_range(200000, 1)), OFFS_W'($urandom),
                            OFFS_W'($urandom));
        for (int n = 0; n < 90; n++) begin
            queue_random_item();
        end
        wait_idle();

        // Let the pipeline settle so that a stray late result would be caught.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0) begin
            fail_count += expected_results.size();
        end
        $display("run: %0d items, %0d results, %0d samples, %0d refused adjusts",
                 items_sent, results_seen, samples_seen, rejects_seen);
        $display("     %0d register writes, %0d input stall cycles, %0d failures",
                 cfg_writes, input_stalls, fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
